// ----- rtl/core/ntdv_pkg.sv -----
// ntdv_pkg: shared types and constants of the n-tuple value update unit
// used by ntdv_div and ntuple_td_value_update_unit, depends on nothing

package ntdv_pkg;

	localparam int TILE_BITS  = 5;
	localparam int TILE_COUNT = 4;
	localparam int REV_BITS   = TILE_BITS * TILE_COUNT;
	localparam int TUPLES     = 4;
	localparam int WEIGHT_W   = 32;
	localparam int REWARD_W   = 31;

	typedef logic [WEIGHT_W-1:0] weight_t;

	typedef struct packed {
		logic    start;
		weight_t dividend;
	} div_req_t;

	typedef struct packed {
		logic    done;
		weight_t quotient;
	} div_rsp_t;

	function automatic logic [REV_BITS-1:0] tile_reverse(input logic [REV_BITS-1:0] a);
		logic [REV_BITS-1:0] r;
		r = '0;
		for (int t = 0; t < TILE_COUNT; t++) begin
			r[(TILE_COUNT-1-t)*TILE_BITS +: TILE_BITS] = a[t*TILE_BITS +: TILE_BITS];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ntuple_td_value_update_unit.sv -----
// ntuple_td_value_update_unit: outer and inner weight memories of an n-tuple
// value network with a TD(0) update sequencer, depends on ntdv_pkg and ntdv_div
//
// Input beats on s_* carry one position (eight tuple indices and a reward),
// s_tuser selects evaluate or train and flags the first position of a run.
// Every beat gives one output beat on m_* with the position value and the
// TD error (zero unless the weights were updated).
// cfg_* writes train_enable; it is always ready and is meant for idle times.
// One position is worked on at a time. Evaluate, first-of-run, disabled train
// beats and train beats with no stored next position read their own weights,
// check and hand off the result; an updating train beat reads its own weights,
// checks, reads the stored next position, forms the delta, waits for the
// reciprocal divider, does a read-modify-write of up to eight entries per
// memory, a read then a write each, and hands off the result, both memories
// working side by side on their single read port.
// After reset both memories are cleared one entry per cycle, all 2^INDEX_BITS
// entries, with s_tready low. A stalled receiver holds the result in the
// output register; the next beat is still taken and waits for it at its end.

module ntuple_td_value_update_unit
	import ntdv_pkg::*;
#(
	parameter int INDEX_BITS   = 20,
	parameter int REWARD_SCALE = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,   // train_enable
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// reward, outer_idx0..3, inner_idx0..3, zero pad
	input  logic [((REWARD_W + 2*TUPLES*INDEX_BITS + 7)/8)*8-1:0] s_tdata,
	input  logic [1:0]              s_tuser,    // func, first_of_run
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [2*WEIGHT_W-1:0]   m_tdata     // position_value, td_error
);

	localparam int EXT_W = (INDEX_BITS > REV_BITS) ? INDEX_BITS : REV_BITS;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b0000000001,
		ST_IDLE    = 10'b0000000010,
		ST_RD_OWN  = 10'b0000000100,
		ST_CHECK   = 10'b0000001000,
		ST_RD_NEXT = 10'b0000010000,
		ST_DELTA   = 10'b0000100000,
		ST_DIVIDE  = 10'b0001000000,
		ST_UPD_RD  = 10'b0010000000,
		ST_UPD_WR  = 10'b0100000000,
		ST_FINISH  = 10'b1000000000
	} state_t;

	typedef logic [INDEX_BITS-1:0] index_t;

	state_t  state_q;
	logic [2:0] cnt_q;
	logic [2:0] upd_q;
	index_t  clr_addr_q;
	logic    rd_pend_s1;
	logic    m_tvalid_q;
	logic    train_enable_q;
	logic    next_valid_q;
	index_t  nxt_o_q [TUPLES];
	index_t  nxt_i_q [TUPLES];
	logic [REWARD_W-1:0] nxt_reward_q;

	index_t  cur_o_q [TUPLES];
	index_t  cur_i_q [TUPLES];
	logic [REWARD_W-1:0] cur_reward_q;
	logic    func_q;
	logic    first_q;
	weight_t acc_q;
	weight_t own_q;
	weight_t delta_q;
	weight_t step_q;
	weight_t value_q;
	weight_t td_error_q;
	weight_t o_rdata_q;
	weight_t i_rdata_q;

	weight_t outer_mem [2**INDEX_BITS];
	weight_t inner_mem [2**INDEX_BITS];

	logic    in_beat;
	logic    rd_issue;
	logic    in_upd;
	logic [1:0] sel;
	index_t  o_cur;
	index_t  i_cur;
	index_t  o_rev;
	index_t  i_rev;
	index_t  o_uaddr;
	index_t  i_uaddr;
	logic    o_uen;
	logic    i_uen;
	index_t  o_raddr;
	index_t  i_raddr;
	logic    o_we;
	logic    i_we;
	index_t  o_waddr;
	index_t  i_waddr;
	weight_t o_wdata;
	weight_t i_wdata;
	logic    do_update;
	logic    out_load;
	weight_t delta_next;
	div_req_t div_req;
	div_rsp_t div_rsp;

	function automatic index_t rev_index(input index_t a);
		logic [EXT_W-1:0]    ext;
		logic [REV_BITS-1:0] r;
		logic [EXT_W-1:0]    rext;
		ext  = EXT_W'(a);
		r    = tile_reverse(ext[REV_BITS-1:0]);
		rext = EXT_W'(r);
		return rext[INDEX_BITS-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {td_error_q, value_q};

	assign rd_issue = ((state_q == ST_RD_OWN) || (state_q == ST_RD_NEXT)) && !cnt_q[2];
	assign in_upd   = (state_q == ST_UPD_RD) || (state_q == ST_UPD_WR);
	assign sel      = in_upd ? upd_q[2:1] : cnt_q[1:0];
	assign o_cur    = cur_o_q[sel];
	assign i_cur    = cur_i_q[sel];
	assign o_rev    = rev_index(o_cur);
	assign i_rev    = rev_index(i_cur);
	assign o_uaddr  = upd_q[0] ? o_rev : o_cur;
	assign i_uaddr  = upd_q[0] ? i_rev : i_cur;
	assign o_uen    = !upd_q[0] || (o_rev != o_cur);
	assign i_uen    = !upd_q[0] || (i_rev != i_cur);

	assign do_update  = func_q && train_enable_q && !first_q && next_valid_q;
	assign out_load   = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
	assign delta_next = acc_q + WEIGHT_W'(nxt_reward_q) - own_q;

	always_comb begin
		case (state_q)
			ST_RD_NEXT: begin
				o_raddr = nxt_o_q[cnt_q[1:0]];
				i_raddr = nxt_i_q[cnt_q[1:0]];
			end
			ST_UPD_RD: begin
				o_raddr = o_uaddr;
				i_raddr = i_uaddr;
			end
			default: begin
				o_raddr = o_cur;
				i_raddr = i_cur;
			end
		endcase
	end

	always_comb begin
		o_we    = 1'b0;
		i_we    = 1'b0;
		o_waddr = o_uaddr;
		i_waddr = i_uaddr;
		o_wdata = o_rdata_q + step_q;
		i_wdata = i_rdata_q + step_q;
		case (state_q)
			ST_CLEAR: begin
				o_we    = 1'b1;
				i_we    = 1'b1;
				o_waddr = clr_addr_q;
				i_waddr = clr_addr_q;
				o_wdata = '0;
				i_wdata = '0;
			end
			ST_UPD_WR: begin
				o_we = o_uen;
				i_we = i_uen;
			end
			default: begin
				o_we = 1'b0;
				i_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (o_we) begin
			outer_mem[o_waddr] <= o_wdata;
		end
		o_rdata_q <= outer_mem[o_raddr];
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			inner_mem[i_waddr] <= i_wdata;
		end
		i_rdata_q <= inner_mem[i_raddr];
	end

	assign div_req.start    = (state_q == ST_DELTA);
	assign div_req.dividend = delta_next;

	ntdv_div #(
		.DIVISOR (REWARD_SCALE)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			upd_q          <= '0;
			clr_addr_q     <= '0;
			rd_pend_s1     <= 1'b0;
			m_tvalid_q     <= 1'b0;
			train_enable_q <= 1'b1;
			next_valid_q   <= 1'b0;
			nxt_reward_q   <= '0;
			for (int k = 0; k < TUPLES; k++) begin
				nxt_o_q[k] <= '0;
				nxt_i_q[k] <= '0;
			end
		end else begin
			rd_pend_s1 <= rd_issue;
			if (cfg_valid) begin
				train_enable_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (out_load && func_q && train_enable_q) begin
				next_valid_q <= 1'b1;
				nxt_reward_q <= cur_reward_q;
				for (int k = 0; k < TUPLES; k++) begin
					nxt_o_q[k] <= cur_o_q[k];
					nxt_i_q[k] <= cur_i_q[k];
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						cnt_q   <= '0;
						state_q <= ST_RD_OWN;
					end
				end
				ST_RD_OWN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[2]) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q   <= '0;
					state_q <= do_update ? ST_RD_NEXT : ST_FINISH;
				end
				ST_RD_NEXT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[2]) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						upd_q   <= '0;
						state_q <= ST_UPD_RD;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					upd_q <= upd_q + 1'b1;
					state_q <= (upd_q == '1) ? ST_FINISH : ST_UPD_RD;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			func_q       <= s_tuser[0];
			first_q      <= s_tuser[1];
			cur_reward_q <= s_tdata[REWARD_W-1:0];
			for (int k = 0; k < TUPLES; k++) begin
				cur_o_q[k] <= s_tdata[REWARD_W + k*INDEX_BITS +: INDEX_BITS];
				cur_i_q[k] <= s_tdata[REWARD_W + (TUPLES + k)*INDEX_BITS +: INDEX_BITS];
			end
		end
		if (in_beat || (state_q == ST_CHECK)) begin
			acc_q <= '0;
		end else if (rd_pend_s1) begin
			acc_q <= acc_q + o_rdata_q + i_rdata_q;
		end
		if (state_q == ST_CHECK) begin
			own_q <= acc_q;
			if (!do_update) begin
				delta_q <= '0;
			end
		end
		if (state_q == ST_DELTA) begin
			delta_q <= delta_next;
		end
		if ((state_q == ST_DIVIDE) && div_rsp.done) begin
			step_q <= div_rsp.quotient;
		end
		if (out_load) begin
			value_q    <= own_q;
			td_error_q <= delta_q;
		end
	end

	// no input beat while the memories are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input taken during clearing pass");

	// weights change only in the clearing pass or the write half of an update
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_we || i_we) |-> ((state_q == ST_CLEAR) || (state_q == ST_UPD_WR)))
		else $error("weight write outside clear or update");

	// divider answers only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVIDE))
		else $error("divider result while not waiting");

	// a held result is never overwritten by the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && m_tvalid_q && !m_tready) |=> (state_q == ST_FINISH))
		else $error("finish left while output slot busy");

	// updates run only for a train beat with a stored next position
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_NEXT) |-> (func_q && next_valid_q && !first_q))
		else $error("update started without a next position");

endmodule

// ----- rtl/core/ntdv_div.sv -----
// ntdv_div: signed division by a constant, truncating toward zero, by a reciprocal
// multiply in two registered 16-bit halves, quotient valid with done, depends on ntdv_pkg

module ntdv_div
	import ntdv_pkg::*;
#(
	parameter int DIVISOR = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int          HALF_W  = WEIGHT_W / 2;
	localparam int          SHIFT   = WEIGHT_W + $clog2(DIVISOR);
	localparam logic [63:0] POW     = 64'd1 << SHIFT;
	localparam logic [63:0] RECIP   = (POW + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam int          RECIP_W = WEIGHT_W + 2;
	localparam int          PART_W  = HALF_W + RECIP_W;
	localparam int          SUM_W   = WEIGHT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MUL = RECIP[RECIP_W-1:0];

	logic              v_s1;
	logic              v_s2;
	logic              done_q;
	logic              neg_q;
	weight_t           mag_s1;
	logic [PART_W-1:0] lo_s2;
	logic [PART_W-1:0] hi_s2;
	logic [SUM_W-1:0]  sum;
	weight_t           quo_q;

	assign sum = {hi_s2, {HALF_W{1'b0}}} + SUM_W'(lo_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= req.start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q  <= req.dividend[WEIGHT_W-1];
			mag_s1 <= req.dividend[WEIGHT_W-1] ? -req.dividend : req.dividend;
		end
		// 16 by 34 bit products
		if (v_s1) begin
			lo_s2 <= PART_W'(mag_s1[HALF_W-1:0]) * PART_W'(MUL);
			hi_s2 <= PART_W'(mag_s1[WEIGHT_W-1:HALF_W]) * PART_W'(MUL);
		end
		if (v_s2) begin
			quo_q <= WEIGHT_W'(sum >> SHIFT);
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_q : quo_q;

endmodule

// ----- tb/sv/tb_ntuple_td_value_update_unit.sv -----
// tb_ntuple_td_value_update_unit: self-checking bench for the n-tuple value update unit,
// predicts position values and td errors with its own weight tables and checks every beat
// depends on ntdv_pkg and ntuple_td_value_update_unit

module tb_ntuple_td_value_update_unit
	import ntdv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W          = 20;
	localparam int SCALE          = 16;
	localparam int TABLE_DEPTH    = 1 << IDX_W;
	localparam int POOL           = 24;
	localparam int TDATA_W        = ((REWARD_W + 2*TUPLES*IDX_W + 7)/8)*8;
	localparam int WATCHDOG_LIMIT = 4 * TABLE_DEPTH;

	typedef enum bit {
		FUNC_EVAL  = 1'b0,
		FUNC_TRAIN = 1'b1
	} func_e;

	typedef struct packed {
		func_e                   func;
		bit                      first;
		bit [REWARD_W-1:0]       reward;
		bit [7:0][IDX_W-1:0]     idx;
	} position_t;

	typedef struct packed {
		bit [WEIGHT_W-1:0] td;
		bit [WEIGHT_W-1:0] value;
	} outcome_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data  = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata   = '0;   // reward, outer_idx0..3, inner_idx0..3, zero pad
	logic [1:0]            s_tuser   = '0;   // func, first_of_run
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [2*WEIGHT_W-1:0] m_tdata;          // position_value, td_error

	// predictor state
	bit [WEIGHT_W-1:0]   outer_w [0:TABLE_DEPTH-1];
	bit [WEIGHT_W-1:0]   inner_w [0:TABLE_DEPTH-1];
	bit [7:0][IDX_W-1:0] next_idx;
	bit [REWARD_W-1:0]   next_reward;
	bit                  next_held;
	bit                  train_on = 1'b1;

	position_t   positions_to_send [$];
	outcome_t    due_outcomes [$];
	bit [IDX_W-1:0] outer_pool [0:POOL-1];
	bit [IDX_W-1:0] inner_pool [0:POOL-1];

	bit          in_taken;
	int unsigned in_gap;
	int unsigned out_stall;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	ntuple_td_value_update_unit #(
		.INDEX_BITS   (IDX_W),
		.REWARD_SCALE (SCALE)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic bit [IDX_W-1:0] swap_tiles(input bit [IDX_W-1:0] a);
		return {a[4:0], a[9:5], a[14:10], a[19:15]};
	endfunction

	function automatic bit [WEIGHT_W-1:0] table_sum(input bit [7:0][IDX_W-1:0] ix);
		bit [WEIGHT_W-1:0] s;
		s = '0;
		for (int i = 0; i < TUPLES; i++) begin
			s += outer_w[ix[i]];
			s += inner_w[ix[TUPLES+i]];
		end
		return s;
	endfunction

	function automatic outcome_t score_and_learn(input position_t p);
		outcome_t          o;
		bit [WEIGHT_W-1:0] step;
		bit [IDX_W-1:0]    r;
		int                d;
		o.value = table_sum(p.idx);
		o.td    = '0;
		if (p.func == FUNC_TRAIN && train_on) begin
			if (!p.first && next_held) begin
				o.td = table_sum(next_idx) + WEIGHT_W'(next_reward) - o.value;
				d    = $signed(o.td);
				step = d / SCALE;
				for (int i = 0; i < TUPLES; i++) begin
					r = swap_tiles(p.idx[i]);
					outer_w[p.idx[i]] += step;
					if (r != p.idx[i])
						outer_w[r] += step;
					r = swap_tiles(p.idx[TUPLES+i]);
					inner_w[p.idx[TUPLES+i]] += step;
					if (r != p.idx[TUPLES+i])
						inner_w[r] += step;
				end
			end
			next_idx    = p.idx;
			next_reward = p.reward;
			next_held   = 1'b1;
		end
		return o;
	endfunction

	// input driver
	always @(negedge clk) begin
		position_t p;
		if (!s_tvalid || in_taken) begin
			if (in_gap != 0) begin
				s_tvalid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (positions_to_send.size() != 0) begin
				p = positions_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {1'b0, p.idx, p.reward};
				s_tuser  <= {p.first, p.func};
				if (gap_pct != 0 && $urandom_range(99) < gap_pct)
					in_gap <= $urandom_range(10, 1);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		if (out_stall != 0) begin
			m_tready  <= 1'b0;
			out_stall <= out_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (stall_pct != 0 && $urandom_range(99) < stall_pct)
				out_stall <= $urandom_range(10, 1);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				train_on = cfg_data;
			if (s_tvalid && s_tready)
				due_outcomes.push_back(score_and_learn(position_t'({s_tuser[0], s_tuser[1],
					s_tdata[REWARD_W-1:0], s_tdata[REWARD_W +: 2*TUPLES*IDX_W]})));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (due_outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result beat value=%0d td=%0d", $realtime,
							$signed(got.value), $signed(got.td));
					mismatches++;
				end else begin
					want = due_outcomes.pop_front();
					if (got.value != want.value || got.td != want.td) begin
						if (mismatches < 10)
							$display("%0t: value exp %0d got %0d, td exp %0d got %0d",
								$realtime, $signed(want.value), $signed(got.value),
								$signed(want.td), $signed(got.td));
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void add_item(input func_e f, input bit first,
		input bit [REWARD_W-1:0] rw, input bit [7:0][IDX_W-1:0] ix);
		position_t p;
		p.func   = f;
		p.first  = first;
		p.reward = rw;
		p.idx    = ix;
		positions_to_send.push_back(p);
	endfunction

	function automatic bit [REWARD_W-1:0] pick_reward();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return REWARD_W'($urandom);
			4:       return REWARD_W'($urandom_range(1 << 20));
			default: return REWARD_W'($urandom_range(5000));
		endcase
	endfunction

	function automatic bit [7:0][IDX_W-1:0] pick_indices(input bit wild);
		bit [7:0][IDX_W-1:0] ix;
		for (int i = 0; i < 8; i++) begin
			if (wild || $urandom_range(99) < 12)
				ix[i] = IDX_W'($urandom);
			else if (i < TUPLES)
				ix[i] = outer_pool[$urandom_range(POOL-1)];
			else
				ix[i] = inner_pool[$urandom_range(POOL-1)];
		end
		if ($urandom_range(9) == 0)
			ix[$urandom_range(3)] = ix[$urandom_range(3)];
		if ($urandom_range(9) == 0)
			ix[4 + $urandom_range(3)] = ix[4 + $urandom_range(3)];
		return ix;
	endfunction

	task automatic settle();
		while (positions_to_send.size() != 0 || s_tvalid || due_outcomes.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_train_enable(input bit on);
		settle();
		cfg_data  <= on;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random_items(input int unsigned n);
		int unsigned count;
		int unsigned len;
		int unsigned kind;
		count = 0;
		while (count < n) begin
			kind = $urandom_range(19);
			if (kind < 14) begin
				len = $urandom_range(12, 2);
				for (int k = 0; k < len; k++) begin
					add_item(FUNC_TRAIN, k == 0, pick_reward(), pick_indices(1'b0));
					if ($urandom_range(99) < 10) begin
						add_item(FUNC_EVAL, 1'($urandom_range(1)), pick_reward(),
							pick_indices(1'b0));
						count++;
					end
				end
				count += len;
			end else if (kind < 17) begin
				add_item(FUNC_EVAL, 1'($urandom_range(1)), pick_reward(),
					pick_indices(1'b0));
				count++;
			end else begin
				add_item(func_e'($urandom_range(1)), 1'($urandom_range(1)), pick_reward(),
					pick_indices(1'($urandom_range(1))));
				count++;
			end
		end
	endtask

	initial begin
		int unsigned phase_gap [0:7];
		int unsigned phase_stall [0:7];
		bit [IDX_W-1:0] a;
		bit [IDX_W-1:0] b;
		phase_gap   = '{20, 0, 40, 10, 60, 25, 15, 0};
		phase_stall = '{20, 30, 0, 50, 10, 25, 40, 0};
		for (int k = 0; k < POOL; k++) begin
			a = IDX_W'($urandom);
			b = IDX_W'($urandom);
			case (k % 3)
				0: begin
					outer_pool[k] = a;
					inner_pool[k] = b;
				end
				1: begin
					outer_pool[k] = swap_tiles(outer_pool[k-1]);
					inner_pool[k] = swap_tiles(inner_pool[k-1]);
				end
				default: begin
					outer_pool[k] = {a[4:0], a[9:5], a[9:5], a[4:0]};
					inner_pool[k] = {b[4:0], b[9:5], b[9:5], b[4:0]};
				end
			endcase
		end
		outer_pool[0] = '0;
		inner_pool[0] = '0;
		outer_pool[1] = '1;
		inner_pool[1] = '1;
		gap_pct   = 30;
		stall_pct = 30;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// train with nothing stored yet, then a run over index zero
		add_item(FUNC_TRAIN, 1'b0, 31'd5000, {20'd8, 20'd7, 20'd6, 20'd5,
			20'd4, 20'd3, 20'd2, 20'd1});
		add_item(FUNC_TRAIN, 1'b0, 31'd0, {8{20'h00000}});
		add_item(FUNC_EVAL, 1'b1, '1, {8{20'h00000}});
		add_item(FUNC_TRAIN, 1'b1, '1, {8{20'hFFFFF}});
		add_item(FUNC_TRAIN, 1'b0, '1, {8{20'h00000}});
		add_item(FUNC_TRAIN, 1'b0, '1, {8{20'h00000}});
		add_item(FUNC_TRAIN, 1'b0, '1, {8{20'h00000}});
		add_item(FUNC_TRAIN, 1'b0, 31'd0, {20'hFFFFF, 20'h6318C, 20'h00000, 20'h0001F,
			20'h12345, 20'h12345, 20'h08000, 20'h00001});
		add_item(FUNC_TRAIN, 1'b0, 31'd1, {8{20'hFFFFF}});
		add_item(FUNC_EVAL, 1'b0, 31'd0, {20'hFFFFF, 20'h6318C, 20'h00000, 20'h0001F,
			20'h12345, 20'h12345, 20'h08000, 20'h00001});
		add_item(FUNC_EVAL, 1'b0, 31'd0, {20'h00000, 20'hF8000, 20'h6318C, 20'h48C91,
			20'h00000, 20'hF8000, 20'h6318C, 20'h48C91});
		add_item(FUNC_EVAL, 1'b0, 31'd0, {8{20'hFFFFF}});

		// disabled training leaves the stored position and the weights alone
		set_train_enable(1'b0);
		add_item(FUNC_TRAIN, 1'b0, 31'd777, {8{20'h00001}});
		add_item(FUNC_TRAIN, 1'b1, '1, {8{20'h00002}});
		add_item(FUNC_EVAL, 1'b0, 31'd0, {8{20'h00000}});
		set_train_enable(1'b1);
		add_item(FUNC_TRAIN, 1'b0, 31'd3, {8{20'h00001}});
		add_item(FUNC_TRAIN, 1'b0, 31'd0, {20'h00001, 20'h08000, 20'h00001, 20'h08000,
			20'h00021, 20'h08400, 20'h00021, 20'h08400});
		add_item(FUNC_EVAL, 1'b1, 31'd0, {8{20'h00001}});

		for (int ph = 0; ph < 8; ph++) begin
			set_train_enable(!(ph == 3 || ph == 6));
			gap_pct   = phase_gap[ph];
			stall_pct = phase_stall[ph];
			add_random_items(228);
		end

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
